@@ sv/hbnt_pkg.sv @@
// Shared constants, types and codes of the heartbeat node table.
package hbnt_pkg;

	localparam int NODE_SLOTS = 128;
	localparam int NODE_BITS  = $clog2(NODE_SLOTS);
	localparam int CNT_BITS   = NODE_BITS + 1;
	localparam int TIME_BITS  = 32;
	localparam int CMP_BITS   = (TIME_BITS > 32) ? TIME_BITS : 32;

	localparam logic [10:0] HB_MASK = 11'h780;
	localparam logic [10:0] HB_BASE = 11'h700;

	localparam logic [31:0] RST_OFFLINE_TO = 32'd3000;
	localparam logic [31:0] RST_DELETE_TO  = 32'd60000;
	localparam logic [7:0]  RST_UNK_CODE   = 8'd255;

	localparam logic [1:0] REG_OFFLINE_TO = 2'd0;
	localparam logic [1:0] REG_DELETE_TO  = 2'd1;
	localparam logic [1:0] REG_UNK_CODE   = 2'd2;

	localparam int IN_W = 64;

	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_SCAN  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUERY,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0]           state;
		logic [TIME_BITS-1:0] last_time;
	} entry_t;

	typedef struct packed {
		logic offline;
		logic expired;
	} age_flags_t;

	typedef struct packed {
		logic [7:0]  deleted_count;
		logic [7:0]  offline_count;
		logic [7:0]  node_total;
		logic [31:0] node_last_time;
		logic [7:0]  node_state;
		logic        node_present;
		logic        was_new;
		logic        frame_accepted;
	} res_t;

	localparam int RES_BITS = $bits(res_t);
	localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

endpackage

@@ sv/hbnt_age.sv @@
// Age of one table entry and its compare against both timeouts.
module hbnt_age
	import hbnt_pkg::*;
(
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] last_time,
	input  logic [31:0]          offline_to,
	input  logic [31:0]          delete_to,
	output age_flags_t           flags
);

	logic [TIME_BITS-1:0] age;
	logic [CMP_BITS-1:0]  age_w;

	always_comb begin
		age           = now - last_time;
		age_w         = CMP_BITS'(age);
		flags.offline = age_w > CMP_BITS'(offline_to);
		flags.expired = age_w > CMP_BITS'(delete_to);
	end

endmodule

@@ sv/heartbeat_node_table.sv @@
// A frame or spare-op item goes from ST_IDLE to ST_DONE, a query through ST_QUERY; ST_DONE loads
// the result into the output register once that register is free. A scan walks every slot
// through the registered entry memory in ST_SCAN before it reaches ST_DONE.
// Items are taken one at a time.
// A new item is taken while a finished result still waits in the output register.
// Reset clears all valid bits at once and loads the timeout and unknown-state defaults.
module heartbeat_node_table
	import hbnt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	// Fields from bit 0: can_id, first_data_byte, time_ms, query_node, zero fill.
	input  logic [IN_W-1:0]  s_tdata,
	// Fields from bit 0: opcode.
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// Fields from bit 0: frame_accepted, was_new, node_present, node_state,
	// node_last_time, node_total, offline_count, deleted_count, zero fill.
	output logic [OUT_W-1:0] m_tdata
);

	state_t state_q, state_d;

	logic [31:0] off_to_q;
	logic [31:0] del_to_q;
	logic [7:0]  unk_code_q;

	logic [NODE_SLOTS-1:0] valid_q;
	logic [7:0]            total_q;
	entry_t                mem_q [NODE_SLOTS];
	entry_t                rd_data_s1;
	logic                  rd_v_s1;
	logic [NODE_BITS-1:0]  idx_s1;
	logic [CNT_BITS-1:0]   scan_cnt_q;
	logic [TIME_BITS-1:0]  now_q;
	res_t                  res_q;
	res_t                  out_q;
	logic                  out_valid_q;

	logic [10:0]          in_can_id;
	logic [7:0]           in_data;
	logic [31:0]          in_time;
	logic [6:0]           in_qnode;
	op_t                  in_op;
	logic [TIME_BITS-1:0] in_now;
	logic                 in_fire;
	logic                 hb_match;
	logic                 frame_ok;
	logic                 query_ok;
	logic [NODE_BITS-1:0] frame_idx;
	logic [NODE_BITS-1:0] query_idx;
	res_t                 acc_res;
	res_t                 done_res;

	logic                 rd_en;
	logic [NODE_BITS-1:0] rd_addr;
	logic                 wr_en;
	logic [NODE_BITS-1:0] wr_addr;
	entry_t               wr_data;
	logic                 out_free;
	logic                 scan_hit;
	age_flags_t           flags;

	assign in_can_id = s_tdata[10:0];
	assign in_data   = s_tdata[18:11];
	assign in_time   = s_tdata[50:19];
	assign in_qnode  = s_tdata[57:51];
	assign in_op     = op_t'(s_tuser);
	assign in_now    = TIME_BITS'(in_time);
	assign in_fire   = s_tvalid & s_tready;
	assign hb_match  = (in_can_id & HB_MASK) == HB_BASE;
	assign frame_ok  = hb_match && ({1'b0, in_can_id[6:0]} < 8'(NODE_SLOTS));
	assign query_ok  = {1'b0, in_qnode} < 8'(NODE_SLOTS);
	assign frame_idx = in_can_id[NODE_BITS-1:0];
	assign query_idx = in_qnode[NODE_BITS-1:0];
	assign out_free  = !out_valid_q || m_tready;
	assign scan_hit  = (state_q == ST_SCAN) && rd_v_s1 && valid_q[idx_s1];

	hbnt_age u_age (
		.now        (now_q),
		.last_time  (rd_data_s1.last_time),
		.offline_to (off_to_q),
		.delete_to  (del_to_q),
		.flags      (flags)
	);

	always_comb begin
		acc_res = '0;
		unique case (in_op)
			OP_FRAME: begin
				acc_res.frame_accepted = hb_match;
				if (frame_ok) begin
					acc_res.was_new        = !valid_q[frame_idx];
					acc_res.node_present   = 1'b1;
					acc_res.node_state     = in_data;
					acc_res.node_last_time = 32'(in_now);
				end
			end
			OP_QUERY: acc_res.node_present = query_ok && valid_q[query_idx];
			default: ;
		endcase
	end

	always_comb begin
		done_res            = res_q;
		done_res.node_total = total_q;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = query_idx;
		wr_en    = 1'b0;
		wr_addr  = frame_idx;
		wr_data  = '{state: in_data, last_time: in_now};
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (in_op)
						OP_FRAME: begin
							wr_en   = frame_ok;
							state_d = ST_DONE;
						end
						OP_SCAN:  state_d = ST_SCAN;
						OP_QUERY: begin
							rd_en   = 1'b1;
							state_d = ST_QUERY;
						end
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_QUERY: state_d = ST_DONE;
			ST_SCAN: begin
				if (scan_cnt_q < CNT_BITS'(NODE_SLOTS)) begin
					rd_en   = 1'b1;
					rd_addr = scan_cnt_q[NODE_BITS-1:0];
				end else if (!rd_v_s1) begin
					state_d = ST_DONE;
				end
				if (scan_hit && flags.offline && !flags.expired) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1;
					wr_data = '{state: unk_code_q, last_time: rd_data_s1.last_time};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
		idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			off_to_q   <= RST_OFFLINE_TO;
			del_to_q   <= RST_DELETE_TO;
			unk_code_q <= RST_UNK_CODE;
			valid_q    <= '0;
			total_q    <= '0;
			rd_v_s1    <= 1'b0;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en && (state_q == ST_SCAN);
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_OFFLINE_TO: off_to_q   <= cfg_wdata;
					REG_DELETE_TO:  del_to_q   <= cfg_wdata;
					REG_UNK_CODE:   unk_code_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				scan_cnt_q <= '0;
				if (in_op == OP_FRAME && frame_ok && !valid_q[frame_idx]) begin
					valid_q[frame_idx] <= 1'b1;
					total_q            <= total_q + 8'd1;
				end
			end
			if (state_q == ST_SCAN && rd_en) begin
				scan_cnt_q <= scan_cnt_q + CNT_BITS'(1);
			end
			if (scan_hit && flags.expired) begin
				valid_q[idx_s1] <= 1'b0;
				if (total_q != 8'd0) begin
					total_q <= total_q - 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= acc_res;
			now_q <= in_now;
		end
		if (state_q == ST_QUERY && res_q.node_present) begin
			res_q.node_state     <= rd_data_s1.state;
			res_q.node_last_time <= 32'(rd_data_s1.last_time);
		end
		if (scan_hit) begin
			if (flags.offline) begin
				res_q.offline_count <= res_q.offline_count + 8'd1;
			end
			if (flags.expired) begin
				res_q.deleted_count <= res_q.deleted_count + 8'd1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= done_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_q);

endmodule

@@ sv/hbnt_checker.sv @@
// Port-level checks of the heartbeat node table and their binding to it.
module hbnt_checker
	import hbnt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	res_t res;

	assign res = m_tdata[RES_BITS-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result item changed while stalled.");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.node_total <= 8'(NODE_SLOTS))
		else $error("Node total exceeds the slot count.");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.was_new |-> res.frame_accepted && res.node_present)
		else $error("New entry reported without an accepted, present node.");

	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.node_present |-> res.node_state == 8'd0 &&
			res.node_last_time == 32'd0)
		else $error("Absent node reported with nonzero fields.");

endmodule

bind heartbeat_node_table hbnt_checker u_hbnt_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the heartbeat node table with a stream-level scoreboard.
module tb_top
	import hbnt_pkg::*;
;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam int         HOLD_CYCLES = 300;

	class node_table_scoreboard;
		logic [31:0]          offline_limit = RST_OFFLINE_TO;
		logic [31:0]          delete_limit  = RST_DELETE_TO;
		logic [7:0]           unknown_code  = RST_UNK_CODE;
		bit                   present [NODE_SLOTS];
		logic [7:0]           state_byte [NODE_SLOTS];
		logic [TIME_BITS-1:0] seen_at [NODE_SLOTS];
		int unsigned          live_nodes;
		res_t                 expected_status [$];
		int errors, checked, n_frames, n_heartbeats, n_scans, n_queries, n_spare;
		int n_offline, n_removed, peak_total;

		function new();
			foreach (present[i]) begin
				present[i] = 1'b0;
				state_byte[i] = '0;
				seen_at[i] = '0;
			end
			live_nodes = 0;
		endfunction

		function void set_limits(logic [31:0] off, logic [31:0] del, logic [7:0] code);
			offline_limit = off;
			delete_limit = del;
			unknown_code = code;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function string describe(res_t v);
			return $sformatf("acc=%0d new=%0d pres=%0d st=%02h last=%08h total=%0d offl=%0d del=%0d",
				v.frame_accepted, v.was_new, v.node_present, v.node_state,
				v.node_last_time, v.node_total, v.offline_count, v.deleted_count);
		endfunction

		function void note_item(logic [1:0] op, logic [IN_W-1:0] item);
			logic [10:0]          id;
			logic [7:0]           b;
			logic [TIME_BITS-1:0] stamp, age;
			logic [6:0]           qn, node;
			res_t                 want;
			int                   offl, del;
			id = item[10:0];
			b = item[18:11];
			stamp = item[50:19];
			qn = item[57:51];
			want = '0;
			offl = 0;
			del = 0;
			case (op)
				OP_FRAME: begin
					n_frames++;
					if ((id & HB_MASK) == HB_BASE) begin
						node = id[6:0];
						n_heartbeats++;
						want.frame_accepted = 1'b1;
						if (node < NODE_SLOTS) begin
							if (!present[node]) begin
								present[node] = 1'b1;
								live_nodes++;
								want.was_new = 1'b1;
							end
							state_byte[node] = b;
							seen_at[node] = stamp;
							want.node_present = 1'b1;
							want.node_state = b;
							want.node_last_time = stamp;
						end
					end
				end
				OP_SCAN: begin
					n_scans++;
					for (int i = 0; i < NODE_SLOTS; i++) begin
						if (present[i]) begin
							age = stamp - seen_at[i];
							if (age > offline_limit) begin
								state_byte[i] = unknown_code;
								offl++;
							end
							if (age > delete_limit) begin
								present[i] = 1'b0;
								state_byte[i] = '0;
								seen_at[i] = '0;
								live_nodes--;
								del++;
							end
						end
					end
					want.offline_count = 8'(offl);
					want.deleted_count = 8'(del);
					n_offline += offl;
					n_removed += del;
				end
				OP_QUERY: begin
					n_queries++;
					if (qn < NODE_SLOTS && present[qn]) begin
						want.node_present = 1'b1;
						want.node_state = state_byte[qn];
						want.node_last_time = seen_at[qn];
					end
				end
				default: begin
					n_spare++;
				end
			endcase
			want.node_total = 8'(live_nodes);
			if (live_nodes > peak_total)
				peak_total = live_nodes;
			expected_status.push_back(want);
		endfunction

		function void check_status(res_t got);
			res_t  want;
			string bad;
			checked++;
			if (expected_status.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing outstanding: %s", describe(got));
				return;
			end
			want = expected_status.pop_front();
			bad = "";
			if (got.frame_accepted !== want.frame_accepted) bad = {bad, " frame_accepted"};
			if (got.was_new !== want.was_new) bad = {bad, " was_new"};
			if (got.node_present !== want.node_present) bad = {bad, " node_present"};
			if (got.node_state !== want.node_state) bad = {bad, " node_state"};
			if (got.node_last_time !== want.node_last_time) bad = {bad, " node_last_time"};
			if (got.node_total !== want.node_total) bad = {bad, " node_total"};
			if (got.offline_count !== want.offline_count) bad = {bad, " offline_count"};
			if (got.deleted_count !== want.deleted_count) bad = {bad, " deleted_count"};
			if (bad != "") begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch in%s", bad);
					$display("  want %s", describe(want));
					$display("  got  %s", describe(got));
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [1:0]        cfg_index;
	logic [31:0]       cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	logic [31:0] now_ms = 32'd0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;

	node_table_scoreboard board = new();

	heartbeat_node_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Signals only change at rising edges, so the falling edge shows what the next edge takes.
	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_tvalid && s_tready)
				board.note_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				board.check_status(res_t'(m_tdata[RES_BITS-1:0]));
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [10:0] id, input logic [7:0] b,
			input logic [31:0] stamp, input logic [6:0] qn);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_W'({qn, stamp, b, id});
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] off, input logic [31:0] del,
			input logic [7:0] code);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_OFFLINE_TO;
		cfg_wdata <= off;
		@(posedge clk);
		cfg_index <= REG_DELETE_TO;
		cfg_wdata <= del;
		@(posedge clk);
		cfg_index <= REG_UNK_CODE;
		cfg_wdata <= {24'($urandom), code};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_limits(off, del, code);
	endtask

	// Mostly heartbeats and queries on a pool of nodes from base, with scans at the running time.
	task automatic run_phase(input int n, input int pool, input logic [6:0] base,
			input logic [31:0] step_max, input bit hold_on, input bit pause_on);
		int          r;
		logic [1:0]  op;
		logic [10:0] id;
		logic [7:0]  b;
		logic [31:0] stamp;
		logic [6:0]  qn, node;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 2) == 0)
				now_ms += $urandom_range(0, step_max);
			id = 11'($urandom);
			b = 8'($urandom);
			stamp = $urandom;
			qn = 7'($urandom);
			node = 7'(base + $urandom_range(0, pool - 1));
			if (r < 50) begin
				op = OP_FRAME;
				if (r < 44)
					id = HB_BASE | 11'(node);
				stamp = (r < 41) ? now_ms : now_ms + $urandom_range(1, 50);
			end else if (r < 62) begin
				op = OP_SCAN;
				stamp = now_ms;
			end else if (r < 95) begin
				op = OP_QUERY;
				if (r < 90)
					qn = node;
			end else begin
				op = OP_SPARE;
			end
			if (hold_on && k == n / 4)
				hold_req = 1'b1;
			if (pause_on && k == n / 2)
				drain();
			send_item(op, id, b, stamp, qn);
		end
	endtask

	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		logic [31:0] off, del;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_OFFLINE_TO;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= OP_FRAME;
		s_tdata <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default timeouts: node zero and the top node, misses, strict boundaries, wrapped ages.
		send_item(OP_FRAME, 11'h700, 8'h00, 32'd1000, 7'h7F);
		send_item(OP_FRAME, 11'h77F, 8'hFF, 32'd1000, 7'h00);
		send_item(OP_FRAME, 11'h700, 8'h55, 32'd1500, 7'h00);
		send_item(OP_FRAME, 11'h6FF, 8'hAA, 32'd1600, 7'h00);
		send_item(OP_FRAME, 11'h780, 8'hAA, 32'd1600, 7'h00);
		send_item(OP_FRAME, 11'h7FF, 8'hAA, 32'd1600, 7'h00);
		send_item(OP_FRAME, 11'h000, 8'hAA, 32'd1600, 7'h00);
		send_item(OP_QUERY, 11'h7FF, 8'hFF, 32'hFFFF_FFFF, 7'h00);
		send_item(OP_QUERY, 11'h000, 8'h00, 32'd0, 7'h7F);
		send_item(OP_QUERY, 11'h000, 8'h00, 32'd0, 7'h05);
		send_item(OP_SPARE, 11'h7FF, 8'hFF, 32'hFFFF_FFFF, 7'h7F);
		send_item(OP_SCAN, 11'h000, 8'h00, 32'd4000, 7'h00);
		send_item(OP_SCAN, 11'h000, 8'h00, 32'd4001, 7'h00);
		send_item(OP_QUERY, 11'h000, 8'h00, 32'd0, 7'h7F);
		send_item(OP_FRAME, 11'h705, 8'hA5, 32'hFFFF_FFFF, 7'h00);
		send_item(OP_SCAN, 11'h000, 8'h00, 32'd61000, 7'h00);
		send_item(OP_SCAN, 11'h000, 8'h00, 32'd61001, 7'h00);
		send_item(OP_QUERY, 11'h000, 8'h00, 32'd0, 7'h05);
		send_item(OP_QUERY, 11'h000, 8'h00, 32'd0, 7'h7F);
		send_item(OP_FRAME, 11'h703, 8'h3C, 32'd0, 7'h00);
		send_item(OP_FRAME, 11'h77E, 8'hC3, 32'hFFFF_FFFF, 7'h00);
		send_item(OP_QUERY, 11'h000, 8'h00, 32'd0, 7'h7E);
		send_item(OP_SPARE, 11'h000, 8'h00, 32'd0, 7'h00);

		// Timeouts that never expire; fill every slot with times spread over the whole range.
		drain();
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
		for (int k = 0; k < NODE_SLOTS; k++)
			send_item(OP_FRAME, HB_BASE | 11'(k), 8'($urandom), $urandom, 7'($urandom));
		now_ms = $urandom;
		run_phase(40, NODE_SLOTS, 7'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);

		// Zero timeouts: the first scan clears a full table.
		drain();
		configure(32'd0, 32'd0, 8'hFF);
		now_ms = $urandom;
		send_item(OP_SCAN, 11'($urandom), 8'($urandom), now_ms, 7'($urandom));
		run_phase(60, 8, 7'($urandom), 32'd3, 1'b0, 1'b0);

		for (int p = 0; p < 7; p++) begin
			off = $urandom_range(20, 600);
			if ($urandom_range(0, 2) == 0)
				del = $urandom_range(1, off);
			else
				del = $urandom_range(off, off * 4);
			drain();
			configure(off, del, 8'($urandom));
			if ($urandom_range(0, 2) == 0)
				now_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * off);
			quiet = (p == 3);
			run_phase(120, $urandom_range(4, 32), 7'($urandom), off / 2 + 1, p == 1, p == 4);
		end
		quiet = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (board.pending() != 0) begin
			$display("%0d expected results never arrived", board.pending());
			board.errors++;
		end
		$display("Run covered %0d frames (%0d heartbeats), %0d scans, %0d queries, %0d spare-op items.",
			board.n_frames, board.n_heartbeats, board.n_scans, board.n_queries, board.n_spare);
		$display("Scans aged out %0d entries and removed %0d; peak table size %0d; %0d results checked.",
			board.n_offline, board.n_removed, board.peak_total, board.checked);
		if (board.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// About eight times the slowest legal run: every item a full-table scan behind long gaps.
	initial begin
		#20_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
